>>> rtl/core/obb_pkg.sv
// Shared types, constants and the arctangent table of the box contact pipeline.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
`default_nettype none

package obb_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CORDIC_XW    = 34;
    localparam int GAIN_Q30     = 652032874;
    localparam int NUM_AXES     = 4;
    localparam int HALF_W       = 16;
    localparam int DEPTH_W      = 18;
    localparam int DEPTH_MAX    = 262143;
    localparam int DEPTH_SHIFT  = 28;
    localparam int CENTRE_SHIFT = 14;

    typedef logic signed [15:0] t_trig;
    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [1:0]         t_axis_idx;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/obb_in_if.sv
// Input channel carrying one pair of oriented boxes per item.
// Depends on obb_pkg for the half size type.
`default_nettype none

interface obb_in_if #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_a_x;
    logic signed [COORD_WIDTH-1:0] center_a_y;
    logic [ANGLE_WIDTH-1:0]        angle_a;
    obb_pkg::t_half                half_width_a;
    obb_pkg::t_half                half_height_a;
    logic signed [COORD_WIDTH-1:0] center_b_x;
    logic signed [COORD_WIDTH-1:0] center_b_y;
    logic [ANGLE_WIDTH-1:0]        angle_b;
    obb_pkg::t_half                half_width_b;
    obb_pkg::t_half                half_height_b;

    modport source (
        output valid, center_a_x, center_a_y, angle_a, half_width_a, half_height_a,
        output center_b_x, center_b_y, angle_b, half_width_b, half_height_b,
        input  ready
    );
    modport sink (
        input  valid, center_a_x, center_a_y, angle_a, half_width_a, half_height_a,
        input  center_b_x, center_b_y, angle_b, half_width_b, half_height_b,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/obb_out_if.sv
// Result channel carrying hit flag, contact normal and depth per item.
// Depends on obb_pkg for the normal and depth widths.
`default_nettype none

interface obb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    obb_pkg::t_trig                normal_x;
    obb_pkg::t_trig                normal_y;
    logic [obb_pkg::DEPTH_W-1:0]   depth;

    modport source (output valid, hit, normal_x, normal_y, depth, input ready);
    modport sink (input valid, hit, normal_x, normal_y, depth, output ready);
endinterface

`default_nettype wire

>>> rtl/core/obb_cordic.sv
// Fully pipelined rotation CORDIC giving cosine and sine of an angle in Q1.14.
// Depends on obb_pkg for the arctangent table, gain and stage count.
`default_nettype none

module obb_cordic #(
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [ANGLE_WIDTH-1:0] i_angle,
    output obb_pkg::t_trig              o_cos,
    output obb_pkg::t_trig              o_sin
);
    localparam int XW = obb_pkg::CORDIC_XW;
    localparam int N  = obb_pkg::CORDIC_STEPS;

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [XW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];
    logic [31:0]          phase;
    logic signed [XW-1:0] map_c;
    logic signed [XW-1:0] map_s;
    obb_pkg::t_trig       r_cos;
    obb_pkg::t_trig       r_sin;

    function automatic obb_pkg::t_trig to_q14(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        t = $signed({v[XW-1], v}) + $signed((XW+1)'(32768));
        t = t >>> 16;
        if (t > $signed((XW+1)'(16384))) begin
            t = $signed((XW+1)'(16384));
        end else if (t < -$signed((XW+1)'(16384))) begin
            t = -$signed((XW+1)'(16384));
        end
        return t[15:0];
    endfunction

    assign phase = {i_angle, (32-ANGLE_WIDTH)'(0)};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= XW'(obb_pkg::GAIN_Q30);
            r_y[0] <= '0;
            r_z[0] <= $signed(XW'(phase[29:0]));
            r_q[0] <= phase[31:30];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed(XW'(obb_pkg::atan_turn(i)));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed(XW'(obb_pkg::atan_turn(i)));
                end
            end
        end
    end

    always_comb begin
        unique case (r_q[N])
            2'd0: begin map_c = r_x[N];  map_s = r_y[N];  end
            2'd1: begin map_c = -r_y[N]; map_s = r_x[N];  end
            2'd2: begin map_c = -r_x[N]; map_s = -r_y[N]; end
            2'd3: begin map_c = r_y[N];  map_s = -r_x[N]; end
            default: begin map_c = r_x[N]; map_s = r_y[N]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= to_q14(map_c);
            r_sin <= to_q14(map_s);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

`default_nettype wire

>>> rtl/core/obb_proj.sv
// Two pipeline stages projecting both boxes onto the four axes as centre and radius.
// Depends on obb_pkg for trig and half size types.
`default_nettype none

module obb_proj #(
    parameter int COORD_WIDTH = 24,
    parameter int PW          = 56
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  obb_pkg::t_trig                     i_cos [0:1],
    input  obb_pkg::t_trig                     i_sin [0:1],
    input  wire logic signed [COORD_WIDTH-1:0] i_cx  [0:1],
    input  wire logic signed [COORD_WIDTH-1:0] i_cy  [0:1],
    input  obb_pkg::t_half                     i_hw  [0:1],
    input  obb_pkg::t_half                     i_hh  [0:1],
    output logic                               o_vld,
    output obb_pkg::t_trig                     o_ax  [0:3],
    output obb_pkg::t_trig                     o_ay  [0:3],
    output logic signed [PW-1:0]               o_cen [0:1][0:3],
    output logic signed [PW-1:0]               o_rad [0:1][0:3],
    output logic [3:0]                         o_flip
);
    localparam int CDW = COORD_WIDTH + 17;
    localparam int MW  = 49;

    obb_pkg::t_trig        ax   [0:3];
    obb_pkg::t_trig        ay   [0:3];
    logic signed [MW-1:0]  mh   [0:1][0:3];
    logic signed [MW-1:0]  mw   [0:1][0:3];

    logic                  r_vld1;
    obb_pkg::t_trig        r_ax1 [0:3];
    obb_pkg::t_trig        r_ay1 [0:3];
    logic signed [31:0]    r_dh  [0:1][0:3];
    logic signed [31:0]    r_dw  [0:1][0:3];
    logic signed [CDW-1:0] r_dc  [0:1][0:3];
    obb_pkg::t_half        r_hw  [0:1];
    obb_pkg::t_half        r_hh  [0:1];

    logic                  r_vld2;
    obb_pkg::t_trig        r_ax2 [0:3];
    obb_pkg::t_trig        r_ay2 [0:3];
    logic signed [PW-1:0]  r_cen [0:1][0:3];
    logic signed [PW-1:0]  r_rad [0:1][0:3];
    logic [3:0]            r_flip;

    always_comb begin
        ax[0] = -i_sin[0]; ay[0] = i_cos[0];
        ax[1] = i_cos[0];  ay[1] = i_sin[0];
        ax[2] = -i_sin[1]; ay[2] = i_cos[1];
        ax[3] = i_cos[1];  ay[3] = i_sin[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int b = 0; b < 2; b++) begin
                r_hw[b] <= i_hw[b];
                r_hh[b] <= i_hh[b];
                for (int k = 0; k < 4; k++) begin
                    r_dh[b][k] <= 32'(i_cos[b]) * 32'(ay[k]) - 32'(i_sin[b]) * 32'(ax[k]);
                    r_dw[b][k] <= 32'(i_cos[b]) * 32'(ax[k]) + 32'(i_sin[b]) * 32'(ay[k]);
                    r_dc[b][k] <= CDW'(i_cx[b]) * CDW'(ax[k]) + CDW'(i_cy[b]) * CDW'(ay[k]);
                end
            end
            for (int k = 0; k < 4; k++) begin
                r_ax1[k] <= ax[k];
                r_ay1[k] <= ay[k];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < 4; k++) begin
                mh[b][k] = $signed(MW'({1'b0, r_hh[b]})) * MW'(r_dh[b][k]);
                mw[b][k] = $signed(MW'({1'b0, r_hw[b]})) * MW'(r_dw[b][k]);
                if (mh[b][k] < 0) mh[b][k] = -mh[b][k];
                if (mw[b][k] < 0) mw[b][k] = -mw[b][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_ax2[k]  <= r_ax1[k];
                r_ay2[k]  <= r_ay1[k];
                r_flip[k] <= r_dc[0][k] < r_dc[1][k];
                for (int b = 0; b < 2; b++) begin
                    r_cen[b][k] <= PW'(r_dc[b][k]) <<< obb_pkg::CENTRE_SHIFT;
                    r_rad[b][k] <= PW'(mh[b][k]) + PW'(mw[b][k]);
                end
            end
        end
    end

    assign o_vld  = r_vld2;
    assign o_ax   = r_ax2;
    assign o_ay   = r_ay2;
    assign o_cen  = r_cen;
    assign o_rad  = r_rad;
    assign o_flip = r_flip;
endmodule

`default_nettype wire

>>> rtl/core/obb_select.sv
// Overlap test per axis, then choice of the least overlap and the result register.
// Depends on obb_pkg for depth width, saturation limit and trig type.
`default_nettype none

module obb_select #(
    parameter int PW = 56
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  obb_pkg::t_trig             i_ax  [0:3],
    input  obb_pkg::t_trig             i_ay  [0:3],
    input  wire logic signed [PW-1:0]  i_cen [0:1][0:3],
    input  wire logic signed [PW-1:0]  i_rad [0:1][0:3],
    input  wire logic [3:0]            i_flip,
    output logic                       o_vld,
    output logic                       o_hit,
    output obb_pkg::t_trig             o_nx,
    output obb_pkg::t_trig             o_ny,
    output logic [obb_pkg::DEPTH_W-1:0] o_depth
);
    localparam int OW = PW + 1;
    localparam int SW = OW - obb_pkg::DEPTH_SHIFT;

    logic signed [PW-1:0]  hi_a [0:3];
    logic signed [PW-1:0]  lo_a [0:3];
    logic signed [PW-1:0]  hi_b [0:3];
    logic signed [PW-1:0]  lo_b [0:3];

    logic                  r_vld3;
    logic [3:0]            r_sep;
    logic signed [OW-1:0]  r_ov  [0:3];
    obb_pkg::t_trig        r_ax3 [0:3];
    obb_pkg::t_trig        r_ay3 [0:3];
    logic [3:0]            r_flip3;

    obb_pkg::t_axis_idx    p01;
    obb_pkg::t_axis_idx    p23;
    obb_pkg::t_axis_idx    sel;
    logic [SW-1:0]         shifted;

    logic                  r_vld4;
    logic                  r_hit;
    obb_pkg::t_trig        r_nx;
    obb_pkg::t_trig        r_ny;
    logic [obb_pkg::DEPTH_W-1:0] r_depth;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hi_a[k] = i_cen[0][k] + i_rad[0][k];
            lo_a[k] = i_cen[0][k] - i_rad[0][k];
            hi_b[k] = i_cen[1][k] + i_rad[1][k];
            lo_b[k] = i_cen[1][k] - i_rad[1][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip3 <= i_flip;
            for (int k = 0; k < 4; k++) begin
                r_ax3[k] <= i_ax[k];
                r_ay3[k] <= i_ay[k];
                r_sep[k] <= (hi_a[k] < lo_b[k]) || (hi_b[k] < lo_a[k]);
                r_ov[k]  <= OW'((hi_a[k] < hi_b[k]) ? hi_a[k] : hi_b[k])
                          - OW'((lo_a[k] > lo_b[k]) ? lo_a[k] : lo_b[k]);
            end
        end
    end

    // Strict compares keep the earlier axis on equal overlaps.
    always_comb begin
        p01 = (r_ov[1] < r_ov[0]) ? 2'd1 : 2'd0;
        p23 = (r_ov[3] < r_ov[2]) ? 2'd3 : 2'd2;
        sel = (r_ov[p23] < r_ov[p01]) ? p23 : p01;
        shifted = SW'(r_ov[sel] >>> obb_pkg::DEPTH_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sep != 4'd0) begin
                r_hit   <= 1'b0;
                r_nx    <= '0;
                r_ny    <= '0;
                r_depth <= '0;
            end else begin
                r_hit <= 1'b1;
                r_nx  <= r_flip3[sel] ? -r_ax3[sel] : r_ax3[sel];
                r_ny  <= r_flip3[sel] ? -r_ay3[sel] : r_ay3[sel];
                if (shifted > SW'(obb_pkg::DEPTH_MAX)) begin
                    r_depth <= obb_pkg::DEPTH_W'(obb_pkg::DEPTH_MAX);
                end else begin
                    r_depth <= shifted[obb_pkg::DEPTH_W-1:0];
                end
            end
        end
    end

    assign o_vld   = r_vld4;
    assign o_hit   = r_hit;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_depth = r_depth;
endmodule

`default_nettype wire

>>> rtl/core/obb_obb_contact.sv
// Separating axis contact test for two OBBs, one pair per clock when not stalled.
// Depends on obb_pkg, obb_in_if, obb_out_if, obb_cordic, obb_proj and obb_select.
//
// Usage: i_box carries one pair of boxes per item (centre Q.8, angle in turns,
// half sizes Q8.8); o_res returns one item per pair with hit, the contact
// normal in Q1.14 pointing from box B toward box A, and the least overlap.
// A result becomes valid once the accepted pair has passed the sine and cosine
// pipelines (one register per CORDIC iteration), the axis projections and the
// overlap test and axis choice, in that order.
// Throughput is one item per unstalled cycle; the whole pipeline moves as one.
// When the receiver holds o_res.ready low while a result waits, every stage
// holds and i_box.ready falls in the same cycle, so no item is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module obb_obb_contact #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    obb_in_if.sink    i_box,
    obb_out_if.source o_res
);
    localparam int LAT = obb_pkg::CORDIC_LAT;
    localparam int PW  = ((COORD_WIDTH + 31 > 50) ? COORD_WIDTH + 31 : 50) + 1;

    logic                          en;
    logic                          r_vld [0:LAT-1];
    logic signed [COORD_WIDTH-1:0] r_cx  [0:LAT-1][0:1];
    logic signed [COORD_WIDTH-1:0] r_cy  [0:LAT-1][0:1];
    obb_pkg::t_half                r_hw  [0:LAT-1][0:1];
    obb_pkg::t_half                r_hh  [0:LAT-1][0:1];

    obb_pkg::t_trig                cs    [0:1];
    obb_pkg::t_trig                sn    [0:1];

    logic                          p_vld;
    obb_pkg::t_trig                p_ax  [0:3];
    obb_pkg::t_trig                p_ay  [0:3];
    logic signed [PW-1:0]          p_cen [0:1][0:3];
    logic signed [PW-1:0]          p_rad [0:1][0:3];
    logic [3:0]                    p_flip;

    assign en          = !o_res.valid || o_res.ready;
    assign i_box.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_box.valid;
            for (int s = 1; s < LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0][0] <= i_box.center_a_x;
            r_cy[0][0] <= i_box.center_a_y;
            r_hw[0][0] <= i_box.half_width_a;
            r_hh[0][0] <= i_box.half_height_a;
            r_cx[0][1] <= i_box.center_b_x;
            r_cy[0][1] <= i_box.center_b_y;
            r_hw[0][1] <= i_box.half_width_b;
            r_hh[0][1] <= i_box.half_height_b;
            for (int s = 1; s < LAT; s++) begin
                r_cx[s] <= r_cx[s-1];
                r_cy[s] <= r_cy[s-1];
                r_hw[s] <= r_hw[s-1];
                r_hh[s] <= r_hh[s-1];
            end
        end
    end

    obb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_box.angle_a),
        .o_cos   (cs[0]),
        .o_sin   (sn[0])
    );

    obb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_box.angle_b),
        .o_cos   (cs[1]),
        .o_sin   (sn[1])
    );

    obb_proj #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[LAT-1]),
        .i_cos   (cs),
        .i_sin   (sn),
        .i_cx    (r_cx[LAT-1]),
        .i_cy    (r_cy[LAT-1]),
        .i_hw    (r_hw[LAT-1]),
        .i_hh    (r_hh[LAT-1]),
        .o_vld   (p_vld),
        .o_ax    (p_ax),
        .o_ay    (p_ay),
        .o_cen   (p_cen),
        .o_rad   (p_rad),
        .o_flip  (p_flip)
    );

    obb_select #(.PW(PW)) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p_vld),
        .i_ax    (p_ax),
        .i_ay    (p_ay),
        .i_cen   (p_cen),
        .i_rad   (p_rad),
        .i_flip  (p_flip),
        .o_vld   (o_res.valid),
        .o_hit   (o_res.hit),
        .o_nx    (o_res.normal_x),
        .o_ny    (o_res.normal_y),
        .o_depth (o_res.depth)
    );
endmodule

`default_nettype wire
